@@ hdl/xtea_pkg.sv @@
// Shared types, constants and the round mixing function for the chained-key XTEA block.
// No dependencies; imported by every module under hdl.

package xtea_pkg;

    localparam logic [31:0] DELTA         = 32'h9E37_79B9;
    localparam int          WORD_W        = 32;
    localparam int          KEY_WORDS     = 4;
    localparam int          ROUND_W       = 7;
    localparam int          XOR_W         = 8;
    localparam int          CFG_IDX_W     = 3;
    localparam int          HALF_W        = ROUND_W + 1;
    localparam logic [ROUND_W-1:0] RESET_ROUNDS = 7'd32;
    localparam logic [WORD_W-1:0]  RESET_DEC_SUM = 32'hC6EF_3720;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_XOR    = 3'd4,
        CFG_ROUNDS = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] word_first;
        logic [WORD_W-1:0] word_second;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] out_first;
        logic [WORD_W-1:0] out_second;
    } t_out;

    typedef struct packed {
        logic load;
        logic step;
        logic phase;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [ROUND_W-1:0] round_count;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
        mix = ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

@@ hdl/xtea_dp.sv @@
// Datapath: configuration registers, working key, block words and one shared half-round unit.
// Depends on xtea_pkg; driven by commands from xtea_ctrl.

module xtea_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [xtea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]  i_cfg_data,
    input  xtea_pkg::t_in                i_in_data,
    input  xtea_pkg::t_dp_cmd            i_cmd,
    output xtea_pkg::t_dp_stat           o_stat,
    output xtea_pkg::t_out               o_out_data
);
    import xtea_pkg::*;

    logic [WORD_W-1:0]  r_cfg_key [KEY_WORDS];
    logic [WORD_W-1:0]  n_cfg_key [KEY_WORDS];
    logic [XOR_W-1:0]   r_xor, n_xor;
    logic [ROUND_W-1:0] r_rounds;
    logic [WORD_W-1:0]  r_dec_sum;
    logic [WORD_W-1:0]  r_wkey [KEY_WORDS];
    logic               r_enc;
    logic [WORD_W-1:0]  r_v0, r_v1, r_in0, r_in1, r_sum;
    t_out               r_out;

    logic               reload;
    logic [WORD_W-1:0]  rep;
    logic               src_v1;
    logic [WORD_W-1:0]  src, tgt, f, tgt_new;
    logic [1:0]         kidx;
    logic [WORD_W-1:0]  c0, c1;

    always_comb begin
        for (int k = 0; k < KEY_WORDS; k++) begin
            n_cfg_key[k] = r_cfg_key[k];
        end
        n_xor  = r_xor;
        reload = 1'b0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
                    n_cfg_key[i_cfg_index[1:0]] = i_cfg_data;
                    reload = 1'b1;
                end
                CFG_XOR: begin
                    n_xor  = i_cfg_data[XOR_W-1:0];
                    reload = 1'b1;
                end
                default: begin
                    reload = 1'b0;
                end
            endcase
        end
        rep = {KEY_WORDS{n_xor}};
    end

    always_comb begin
        src_v1  = r_enc ^ i_cmd.phase;
        src     = src_v1 ? r_v1 : r_v0;
        tgt     = src_v1 ? r_v0 : r_v1;
        kidx    = src_v1 ? r_sum[1:0] : r_sum[12:11];
        f       = mix(src) ^ (r_sum + r_wkey[kidx]);
        tgt_new = r_enc ? tgt + f : tgt - f;
        c0      = r_enc ? r_v0 : r_in0;
        c1      = r_enc ? r_v1 : r_in1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_cfg_key[k] <= '0;
                r_wkey[k]    <= '0;
            end
            r_xor     <= '0;
            r_rounds  <= RESET_ROUNDS;
            r_dec_sum <= RESET_DEC_SUM;
        end else begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_cfg_key[k] <= n_cfg_key[k];
            end
            r_xor <= n_xor;
            if (i_cfg_valid && i_cfg_index == CFG_ROUNDS) begin
                r_rounds  <= i_cfg_data[ROUND_W-1:0];
                r_dec_sum <= WORD_W'(DELTA * i_cfg_data[ROUND_W-1:0]);
            end
            if (reload) begin
                for (int k = 0; k < KEY_WORDS; k++) begin
                    r_wkey[k] <= n_cfg_key[k] ^ rep;
                end
            end else if (i_cmd.finish) begin
                r_wkey[0] <= r_wkey[0] ^ c0;
                r_wkey[1] <= r_wkey[1] ^ c1;
                r_wkey[2] <= r_wkey[2] ^ c0;
                r_wkey[3] <= r_wkey[3] ^ c1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_enc <= i_in_data.action;
            r_v0  <= i_in_data.word_first;
            r_v1  <= i_in_data.word_second;
            r_in0 <= i_in_data.word_first;
            r_in1 <= i_in_data.word_second;
            r_sum <= i_in_data.action ? '0 : r_dec_sum;
        end else if (i_cmd.step) begin
            if (src_v1) begin
                r_v0 <= tgt_new;
            end else begin
                r_v1 <= tgt_new;
            end
            if (!i_cmd.phase) begin
                r_sum <= r_enc ? r_sum + DELTA : r_sum - DELTA;
            end
        end
        if (i_cmd.finish) begin
            r_out.out_first  <= r_v0;
            r_out.out_second <= r_v1;
        end
    end

    assign o_stat.round_count = r_rounds;
    assign o_out_data         = r_out;

endmodule

@@ hdl/xtea_ctrl.sv @@
// Controller: sequences load, half-round steps and finish, and owns the result valid flag.
// Depends on xtea_pkg; commands xtea_dp.

module xtea_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  xtea_pkg::t_dp_stat i_stat,
    output xtea_pkg::t_dp_cmd  o_cmd
);
    import xtea_pkg::*;

    t_state             r_state, n_state;
    logic [HALF_W-1:0]  r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        slot_free   = !r_out_valid || !i_out_stall;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = (r_state != ST_IDLE);
        o_cmd.phase = r_cnt[0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = {i_stat.round_count, 1'b0};
                    n_state    = (i_stat.round_count == '0) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - HALF_W'(1);
                if (r_cnt == HALF_W'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || !i_out_stall))
        else $error("finish overwrote a pending result");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finish did not raise result valid");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cnt != '0))
        else $error("running with no half-rounds left");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_in_stall)
        else $error("input not stalled after load");

endmodule

@@ hdl/xtea_chained_key_cipher.sv @@
// Top level of the chained-key XTEA cipher: joins xtea_ctrl and xtea_dp.
// Depends on xtea_pkg, xtea_ctrl, xtea_dp.
// A request is loaded, runs its half-round steps (R = round_count; R=0 runs none), and then finishes.
// The single shared half-round adder unit serves one block at a time; no new request is taken until it finishes.
// A new request is taken while a finished result still waits downstream.
// Reset (synchronous, active low): zero key and XOR byte, 32 rounds, working key zero.

module xtea_chained_key_cipher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  xtea_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output xtea_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xtea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]    i_cfg_data
);
    import xtea_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    xtea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    xtea_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

@@ tb/xtea_chained_key_cipher_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for xtea_chained_key_cipher: directed and random blocks
// checked against a chained-key XTEA predictor. Depends on xtea_pkg and the block.

module xtea_chained_key_cipher_tb;

    import xtea_pkg::*;

    localparam logic                 ACT_DECRYPT  = 1'b0;
    localparam logic                 ACT_ENCRYPT  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7   = 3'd7;
    localparam int                   PHASE_SETTLE = 4;
    localparam int                   FINAL_SETTLE = 2 * 127 + 4;
    localparam int                   TIMEOUT_NS   = 4_000_000;
    localparam int                   SEGMENT_LEN  = 105;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    logic [WORD_W-1:0]  cfg_key [KEY_WORDS] = '{default: '0};
    logic [XOR_W-1:0]   cfg_xor             = '0;
    logic [ROUND_W-1:0] cfg_rounds          = RESET_ROUNDS;
    logic [WORD_W-1:0]  work_key [KEY_WORDS] = '{default: '0};

    t_out expected_blocks [$];
    t_out oldest_block;
    int   mismatches   = 0;
    int   src_idle_pct = 0;
    int   dst_idle_pct = 0;
    int   hold_len     = 0;
    int   hold_token   = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;

    xtea_chained_key_cipher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out xtea_chain_predict(input t_in blk);
        logic [WORD_W-1:0] v0, v1, c0, c1, s;
        int                r;
        t_out              res;
        v0 = blk.word_first;
        v1 = blk.word_second;
        c0 = v0;
        c1 = v1;
        if (blk.action == ACT_ENCRYPT) begin
            s = '0;
            for (r = 0; r < cfg_rounds; r++) begin
                v0 += (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (s + work_key[s[1:0]]);
                s  += DELTA;
                v1 += (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (s + work_key[s[12:11]]);
            end
            c0 = v0;
            c1 = v1;
        end else begin
            s = DELTA * {{(WORD_W-ROUND_W){1'b0}}, cfg_rounds};
            for (r = 0; r < cfg_rounds; r++) begin
                v1 -= (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (s + work_key[s[12:11]]);
                s  -= DELTA;
                v0 -= (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (s + work_key[s[1:0]]);
            end
        end
        work_key[0] ^= c0;
        work_key[1] ^= c1;
        work_key[2] ^= c0;
        work_key[3] ^= c1;
        res.out_first  = v0;
        res.out_second = v1;
        return res;
    endfunction

    function automatic t_in block_of(input logic act, input logic [WORD_W-1:0] a,
                                     input logic [WORD_W-1:0] b);
        t_in blk;
        blk.action      = act;
        blk.word_first  = a;
        blk.word_second = b;
        return blk;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int p;
        p = $urandom_range(15);
        if (p == 0)
            return '0;
        if (p == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic t_in random_block();
        return block_of(1'($urandom_range(1)), pick_word(), pick_word());
    endfunction

    function automatic logic [ROUND_W-1:0] pick_rounds();
        int                 p;
        logic [ROUND_W-1:0] n;
        p = $urandom_range(99);
        if (p < 5)
            n = '0;
        else if (p < 55)
            n = ROUND_W'($urandom_range(8, 1));
        else if (p < 85)
            n = ROUND_W'($urandom_range(32, 9));
        else if (p < 96)
            n = ROUND_W'($urandom_range(64, 33));
        else
            n = ROUND_W'($urandom_range(127, 65));
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (mismatches < 50)
            $display("%0t ns: %s: got %08h expected %08h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        int k;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
                cfg_key[idx[1:0]] = val;
            end
            CFG_XOR: begin
                cfg_xor = val[XOR_W-1:0];
            end
            CFG_ROUNDS: begin
                cfg_rounds = val[ROUND_W-1:0];
            end
            default: ;
        endcase
        if (idx <= CFG_XOR) begin
            for (k = 0; k < KEY_WORDS; k++)
                work_key[k] = cfg_key[k] ^ {4{cfg_xor}};
        end
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input t_in blk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= blk;
        do @(posedge i_clk); while (o_in_stall);
        expected_blocks.push_back(xtea_chain_predict(blk));
    endtask

    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic shuffle_config();
        int                k;
        logic [WORD_W-1:0] raw;
        for (k = 0; k < KEY_WORDS; k++) begin
            if ($urandom_range(1))
                cfg_write(t_cfg_idx'(k), pick_word());
        end
        if ($urandom_range(1))
            cfg_write(CFG_XOR, ($urandom_range(3) == 0) ? '0 : $urandom());
        if ($urandom_range(3) == 0)
            cfg_write($urandom_range(1) ? CFG_SPARE6 : CFG_SPARE7, $urandom());
        raw = $urandom();
        cfg_write(CFG_ROUNDS, {raw[WORD_W-1:ROUND_W], pick_rounds()});
        cfg_close();
    endtask

    task automatic test_reset_state();
        drain(PHASE_SETTLE);
        send_block(block_of(ACT_ENCRYPT, '0, '0));
        send_block(block_of(ACT_ENCRYPT, '1, '1));
        send_block(block_of(ACT_DECRYPT, '1, '0));
    endtask

    task automatic test_key_load();
        drain(PHASE_SETTLE);
        cfg_write(CFG_KEY0, '1);
        cfg_write(CFG_KEY1, '0);
        cfg_write(CFG_KEY2, 32'h8000_0001);
        cfg_write(CFG_KEY3, 32'h7FFF_FFFE);
        cfg_write(CFG_XOR, 32'hFFFF_FF5A);
        cfg_write(CFG_SPARE6, $urandom());
        cfg_write(CFG_SPARE7, '1);
        cfg_write(CFG_ROUNDS, 32'h0000_0140);
        cfg_close();
        send_block(block_of(ACT_ENCRYPT, '0, '0));
        send_block(block_of(ACT_ENCRYPT, '1, '1));
        send_block(block_of(ACT_DECRYPT, '0, '1));
        send_block(block_of(ACT_DECRYPT, $urandom(), $urandom()));
    endtask

    task automatic test_round_extremes();
        drain(PHASE_SETTLE);
        cfg_write(CFG_ROUNDS, '0);
        cfg_close();
        send_block(block_of(ACT_ENCRYPT, $urandom(), $urandom()));
        send_block(block_of(ACT_DECRYPT, $urandom(), $urandom()));
        drain(PHASE_SETTLE);
        cfg_write(CFG_XOR, '0);
        cfg_write(CFG_ROUNDS, 32'h0000_0001);
        cfg_close();
        send_block(block_of(ACT_ENCRYPT, $urandom(), $urandom()));
        send_block(block_of(ACT_DECRYPT, $urandom(), $urandom()));
        drain(PHASE_SETTLE);
        cfg_write(CFG_ROUNDS, '1);
        cfg_close();
        send_block(block_of(ACT_ENCRYPT, $urandom(), $urandom()));
        send_block(block_of(ACT_DECRYPT, $urandom(), $urandom()));
        drain(PHASE_SETTLE);
        cfg_write(CFG_XOR, 32'h0000_00FF);
        cfg_write(CFG_ROUNDS, 32'd64);
        cfg_close();
        send_block(block_of(ACT_ENCRYPT, $urandom(), $urandom()));
        send_block(block_of(ACT_DECRYPT, $urandom(), $urandom()));
    endtask

    task automatic test_output_hold();
        int n;
        drain(PHASE_SETTLE);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        cfg_write(CFG_ROUNDS, 32'd4);
        cfg_close();
        hold_len = 400;
        hold_token++;
        for (n = 0; n < 12; n++)
            send_block(random_block());
    endtask

    task automatic test_request_pause();
        int n;
        drain(PHASE_SETTLE);
        src_idle_pct = 36;
        dst_idle_pct = 71;
        for (n = 0; n < 6; n++)
            send_block(random_block());
        drain(0);
        for (n = 0; n < 6; n++)
            send_block(random_block());
    endtask

    task automatic test_random_traffic();
        int ph, seg, n;
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 36;
                    dst_idle_pct = 71;
                end
                1: begin
                    src_idle_pct = 71;
                    dst_idle_pct = 36;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < 5; seg++) begin
                drain(PHASE_SETTLE);
                shuffle_config();
                for (n = 0; n < SEGMENT_LEN; n++)
                    send_block(random_block());
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= hold_len;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("result with no request", o_out_data.out_first, '0);
            end else begin
                oldest_block = expected_blocks.pop_front();
                if (o_out_data.out_first !== oldest_block.out_first)
                    report_mismatch("out_first", o_out_data.out_first, oldest_block.out_first);
                if (o_out_data.out_second !== oldest_block.out_second)
                    report_mismatch("out_second", o_out_data.out_second,
                                    oldest_block.out_second);
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_key_load();
        test_round_extremes();
        test_output_hold();
        test_request_pause();
        test_random_traffic();
        drain(FINAL_SETTLE);
        if (expected_blocks.size() != 0)
            report_mismatch("results never returned", expected_blocks.size(), '0);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
